// ===== hw/rtl/ole_pkg.sv =====
`timescale 1ns / 1ps

package ole_pkg;

    // widths of the item and result fields
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int LEN_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_HEAD   = 3'd0,
        OP_TAIL   = 3'd1,
        OP_AT     = 3'd2,
        OP_DELETE = 3'd3,
        OP_SEARCH = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef logic [DATA_W-1:0] word_t;

endpackage

// ===== hw/rtl/ole_mem.sv =====
`timescale 1ns / 1ps

module ole_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  ole_pkg::word_t      wdata,
    input  logic [AW-1:0]       raddr,
    output ole_pkg::word_t      rdata
);

    ole_pkg::word_t mem_reg [DEPTH];
    ole_pkg::word_t rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ordered_list_engine.sv =====
`timescale 1ns / 1ps
// clear, unused codes and rejected inserts give their result straight from idle;
// an insert reads and rewrites each entry it moves up, then writes the new value;
// delete/search read and compare each entry scanned, a delete moves the rest down
// throughput: one item at a time, busy stays high until the result strobe
// the receiver cannot stall: done is high for exactly one cycle with ok and length_now
// reset (rst_n low, async) empties the list; stored entries are not cleared

module ordered_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ole_pkg::OP_W-1:0]           opcode,
    input  logic signed [ole_pkg::DATA_W-1:0]  item_value,
    input  logic [ole_pkg::POS_W-1:0]          position,
    output logic                               done,
    output logic                               ok,
    output logic [ole_pkg::LEN_W-1:0]          length_now
);

    // address width of the entry store and width of the entry count
    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    // common width for position versus count compares
    localparam int CMPW = (CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,    // read entry ptr for the shift-up
        S_UP_WR,    // write it one place higher
        S_PUT,      // drop the new value into its slot
        S_SR_RD,    // read entry ptr for the scan
        S_SR_CMP,   // compare against the item value
        S_DN_RD,    // read entry ptr+1 for the shift-down
        S_DN_WR     // write it one place lower
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic              done_reg, done_next;
    logic              ok_reg, ok_next;

    // item payload, held for the whole operation
    ole_pkg::op_t      op_reg;
    ole_pkg::word_t    val_reg;
    logic [AW-1:0]     pos_reg, pos_next;

    // memory port
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    ole_pkg::word_t    mem_wdata;
    logic [AW-1:0]     mem_raddr;
    ole_pkg::word_t    mem_rdata;

    // accept-time decode
    logic              accept;
    logic [CMPW-1:0]   pos_eff;
    logic              full;
    // scan helpers
    logic              hit;
    logic              at_last;
    logic              next_last;

    assign accept = start && !busy;
    assign full   = (count_reg == CW'(CAPACITY));
    // the single compare unit shared by search and delete
    assign hit    = (mem_rdata == val_reg);
    // ptr is the last stored entry
    assign at_last   = ((CW'(ptr_reg) + CW'(1)) == count_reg);
    // ptr+1 is the last stored entry
    assign next_last = ((CW'(ptr_reg) + CW'(2)) == count_reg);

    always_comb
    begin
        case (ole_pkg::op_t'(opcode))
            ole_pkg::OP_HEAD: pos_eff = '0;
            ole_pkg::OP_TAIL: pos_eff = CMPW'(count_reg);
            default:          pos_eff = CMPW'(position);
        endcase
    end

    ole_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer next state and memory control
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        mem_we     = 1'b0;
        mem_waddr  = ptr_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (ole_pkg::op_t'(opcode))
                        ole_pkg::OP_HEAD, ole_pkg::OP_TAIL, ole_pkg::OP_AT:
                        begin
                            if (full || (pos_eff > CMPW'(count_reg)))
                            begin
                                done_next = 1'b1;
                                ok_next   = 1'b0;
                            end
                            else
                            begin
                                // count and position are below CAPACITY here
                                pos_next = AW'(pos_eff);
                                ptr_next = AW'(count_reg - CW'(1));
                                if (pos_eff == CMPW'(count_reg))
                                begin
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    state_next = S_UP_RD;
                                end
                            end
                        end
                        ole_pkg::OP_DELETE, ole_pkg::OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                                ok_next   = 1'b0;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_SR_RD;
                            end
                        end
                        ole_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                            ok_next    = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            ok_next   = 1'b0;
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                mem_raddr  = ptr_reg;
                state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(ptr_reg + AW'(1));
                mem_wdata = mem_rdata;
                if (ptr_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ptr_next   = AW'(ptr_reg - AW'(1));
                    state_next = S_UP_RD;
                end
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                count_next = CW'(count_reg + CW'(1));
                done_next  = 1'b1;
                ok_next    = 1'b1;
                state_next = S_IDLE;
            end
            S_SR_RD:
            begin
                mem_raddr  = ptr_reg;
                state_next = S_SR_CMP;
            end
            S_SR_CMP:
            begin
                if (hit)
                begin
                    if (op_reg == ole_pkg::OP_SEARCH)
                    begin
                        done_next  = 1'b1;
                        ok_next    = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (at_last)
                    begin
                        count_next = CW'(count_reg - CW'(1));
                        done_next  = 1'b1;
                        ok_next    = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DN_RD;
                    end
                end
                else if (at_last)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next   = AW'(ptr_reg + AW'(1));
                    state_next = S_SR_RD;
                end
            end
            S_DN_RD:
            begin
                mem_raddr  = AW'(ptr_reg + AW'(1));
                state_next = S_DN_WR;
            end
            S_DN_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                ptr_next  = AW'(ptr_reg + AW'(1));
                if (next_last)
                begin
                    count_next = CW'(count_reg - CW'(1));
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
        end
    end

    // item payload capture
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (accept)
        begin
            op_reg  <= ole_pkg::op_t'(opcode);
            val_reg <= item_value;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign ok         = ok_reg;
    // low bits only when the count is wider than the result field
    assign length_now = ole_pkg::LEN_W'(count_reg);

`ifndef SYNTHESIS
    // the list never grows past its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // the result strobe only shows once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while still busy");

    // an accepted item either finishes at once or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done_reg || busy))
        else $error("accepted item dropped");

    // the length only moves together with a result
    a_count_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> done_reg)
        else $error("length changed without a result");

    // a failed item leaves the length alone
    a_fail_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !ok_reg) |-> (count_reg == $past(count_reg)))
        else $error("failed item changed the length");
`endif

endmodule
